>>> rtl/core/rgbycc_pkg.sv
// rgbycc_pkg: constants, coefficient tables and types for the BT.601 color converter
// holds fixed-point widths, scaled matrix coefficients and the result record
// no dependencies
package rgbycc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RGB_W    = 8;

    // forward path: coefficients in millionths, divided by 8
    localparam int FPROD_W = 33;
    localparam int FSUM_W  = 35;
    localparam int FABS_W  = 33;
    localparam int FRAC_SH = 13;
    localparam int NUM_W   = FABS_W + FRAC_SH + 1;
    localparam int DV_W    = 31;
    localparam int QUO_W   = 17;

    localparam logic [16:0] FWD_COEF [3][3] = '{
        '{17'd37375, 17'd73375, 17'd14250},
        '{17'd21092, 17'd41408, 17'd62500},
        '{17'd62500, 17'd52336, 17'd10164}
    };
    // bit k set: subtract the term of sample k
    localparam logic [2:0] FWD_NEG [3] = '{3'b000, 3'b011, 3'b110};

    // divisor is 31250 * denominator, half of it gives round to nearest
    localparam logic [14:0]     DV_SCALE = 15'd31250;
    localparam logic [DV_W-1:0] DV_RESET = 31'd7968750;

    localparam logic [15:0] LUMA_MAX   = 16'd32768;
    localparam logic [15:0] CHROMA_MAX = 16'd16384;

    // inverse path: coefficients in millionths, divided by 8
    localparam int IPROD_W = 35;
    localparam int ISUM_W  = 36;
    localparam int T_W     = 24;
    localparam int TM_W    = 41;
    localparam logic [16:0] INV_LUMA = 17'd125000;
    localparam logic [17:0] INV_RV   = 18'd175250;
    localparam logic [17:0] INV_GU   = 18'd43017;
    localparam logic [17:0] INV_GV   = 18'd89267;
    localparam logic [17:0] INV_BU   = 18'd221500;

    // channel = floor(floor(255 * s / 2^18) / 15625), at least 4000000 clamps to 255
    localparam logic [T_W-1:0] T_SAT    = 24'd4000000;
    localparam logic [18:0]    RECIP    = 19'd274877;
    localparam int             RECIP_SH = 32;
    localparam logic [13:0]    DIV_K    = 14'd15625;

    typedef enum logic {
        MODE_FWD = 1'b0,
        MODE_INV = 1'b1
    } mode_t;

    typedef struct packed {
        logic [15:0]        luma;
        logic signed [15:0] blue_diff;
        logic signed [15:0] red_diff;
        logic [RGB_W-1:0]   red;
        logic [RGB_W-1:0]   green;
        logic [RGB_W-1:0]   blue;
    } result_t;

endpackage

>>> rtl/core/rgb_ypbpr_color_convert.sv
// rgb_ypbpr_color_convert: pipelined BT.601 RGB <-> normalized YPbPr pixel converter
// forward path uses a one-bit-per-stage restoring divider, inverse a reciprocal multiply
// depends on rgbycc_pkg
//
// Usage:
//   s_* channel: one pixel per transfer; s_mode 0 converts red/green/blue samples
//   (0..denominator) to Q15 luma, Pb, Pr; s_mode 1 converts Q15 luma, Pb, Pr to
//   8-bit red/green/blue. Fields of the other direction are ignored on input and
//   returned as zero on output.
//   m_* channel: one result per accepted pixel, in order.
//   cfg_* channel: writes the denominator; cfg_ready is always high. Write it only
//   while no pixel is in flight; a zero denominator acts as one.
//   Throughput: one pixel per cycle while the skid register is empty. The pipeline
//   holds five front stages, the overflow check and 17 quotient-bit stages of the
//   forward divider, and the output register.
//   Reset (aresetn low, synchronous) empties the pipeline and sets the denominator
//   to 255.
//   When m_valid is held with m_ready low, a skid register takes the next finished
//   pixel; after that s_ready drops and the whole pipeline holds until the output drains.
module rgb_ypbpr_color_convert (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [15:0]        s_red_in,
    input  logic [15:0]        s_green_in,
    input  logic [15:0]        s_blue_in,
    input  logic [15:0]        s_luma_in,
    input  logic signed [15:0] s_blue_diff_in,
    input  logic signed [15:0] s_red_diff_in,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_luma_out,
    output logic signed [15:0] m_blue_diff_out,
    output logic signed [15:0] m_red_diff_out,
    output logic [7:0]         m_red_out,
    output logic [7:0]         m_green_out,
    output logic [7:0]         m_blue_out
);

    localparam int QW    = rgbycc_pkg::QUO_W;
    localparam int NW    = rgbycc_pkg::NUM_W;
    localparam int DW    = rgbycc_pkg::DV_W;
    localparam int DIV0  = 5;
    localparam int NST   = DIV0 + QW + 1;
    localparam int LAST  = NST - 1;

    // configuration
    logic [DW-1:0] dv_reg;
    logic [15:0]   den_eff;

    // pipeline control
    logic               en;
    logic [NST-1:0]     vld_reg;
    rgbycc_pkg::mode_t  mode_reg [NST];

    // stage 0: input samples
    logic [15:0]        in_smp_reg [3];
    logic [15:0]        in_y_reg;
    logic signed [15:0] in_pb_reg;
    logic signed [15:0] in_pr_reg;

    // stage 1: products
    logic [rgbycc_pkg::FPROD_W-1:0]        fprod_reg  [3][3];
    logic [rgbycc_pkg::FPROD_W-1:0]        fprod_next [3][3];
    logic [rgbycc_pkg::FPROD_W-1:0]        iy_reg;
    logic signed [rgbycc_pkg::IPROD_W-1:0] irv_reg, igu_reg, igv_reg, ibu_reg;

    // stage 2: matrix sums
    logic signed [rgbycc_pkg::FSUM_W-1:0] fsum_reg  [3];
    logic signed [rgbycc_pkg::FSUM_W-1:0] fsum_next [3];
    logic signed [rgbycc_pkg::ISUM_W-1:0] isum_reg  [3];
    logic signed [rgbycc_pkg::ISUM_W-1:0] isum_next [3];
    logic signed [rgbycc_pkg::ISUM_W-1:0] iy_ext;

    // stage 3: magnitude and sign, scaled inverse value
    logic                                 fneg3_reg [3];
    logic [rgbycc_pkg::FABS_W-1:0]        fabs_reg  [3];
    logic signed [rgbycc_pkg::FSUM_W-1:0] fabs_full [3];
    logic                                 ipos_reg  [3];
    logic [rgbycc_pkg::T_W-1:0]           it_reg    [3];
    logic [41:0]                          iw        [3];

    // stage 4: rounded dividend, reciprocal product
    logic                         fneg4_reg [3];
    logic [NW-1:0]                fnm_reg   [3];
    logic                         izero4_reg [3];
    logic                         isat4_reg  [3];
    logic [21:0]                  it4_reg    [3];
    logic [rgbycc_pkg::TM_W-1:0]  itm_reg    [3];

    // stage 5: quotient estimate and its product
    logic        izero5_reg [3];
    logic        isat5_reg  [3];
    logic [21:0] it5_reg    [3];
    logic [8:0]  iqe_reg    [3];
    logic [22:0] iprod_reg  [3];

    // stage 6: corrected inverse channel
    logic [22:0] idiff [3];
    logic [8:0]  iq    [3];

    // divider stages and inverse result delay line
    logic [NW-1:0]  rem_reg [0:QW][3];
    logic [QW-1:0]  quo_reg [0:QW][3];
    logic           neg_reg [0:QW][3];
    logic           ovf_reg [0:QW][3];
    logic [7:0]     rgb_reg [1:QW][3];

    // output side
    rgbycc_pkg::result_t pd;
    rgbycc_pkg::result_t out_reg;
    rgbycc_pkg::result_t skid_reg;
    logic                m_valid_reg;
    logic                skid_vld_reg;

    logic [QW-1:0] fq   [3];
    logic [QW-1:0] fmag [3];
    logic [15:0]   fval [3];

    //--------------------------------------------------------------------
    // configuration register
    //--------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign den_eff   = (cfg_data == 16'd0) ? 16'd1 : cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= rgbycc_pkg::DV_RESET;
        end else if (cfg_valid) begin
            dv_reg <= DW'(rgbycc_pkg::DV_SCALE) * DW'(den_eff);
        end
    end

    //--------------------------------------------------------------------
    // pipeline control: whole pipe holds only while the skid stage is full
    //--------------------------------------------------------------------
    assign en      = !skid_vld_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    //--------------------------------------------------------------------
    // front stages, combinational parts
    //--------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
                fprod_next[c][k] = rgbycc_pkg::FPROD_W'(rgbycc_pkg::FWD_COEF[c][k])
                                 * rgbycc_pkg::FPROD_W'(in_smp_reg[k]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            fsum_next[c] = '0;
            for (int k = 0; k < 3; k++) begin
                if (rgbycc_pkg::FWD_NEG[c][k]) begin
                    fsum_next[c] = fsum_next[c] - $signed({2'b00, fprod_reg[c][k]});
                end else begin
                    fsum_next[c] = fsum_next[c] + $signed({2'b00, fprod_reg[c][k]});
                end
            end
        end
    end

    assign iy_ext       = rgbycc_pkg::ISUM_W'($signed({1'b0, iy_reg}));
    assign isum_next[0] = iy_ext + rgbycc_pkg::ISUM_W'(irv_reg);
    assign isum_next[1] = iy_ext - rgbycc_pkg::ISUM_W'(igu_reg)
                        - rgbycc_pkg::ISUM_W'(igv_reg);
    assign isum_next[2] = iy_ext + rgbycc_pkg::ISUM_W'(ibu_reg);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            fabs_full[c] = (fsum_reg[c] < 0) ? -fsum_reg[c] : fsum_reg[c];
            // 255 * s as a shift and subtract
            iw[c]    = {isum_reg[c][33:0], 8'b0} - {8'b0, isum_reg[c][33:0]};
            idiff[c] = {1'b0, it5_reg[c]} - iprod_reg[c];
            iq[c]    = iqe_reg[c] + 9'(idiff[c] >= 23'(rgbycc_pkg::DIV_K));
        end
    end

    //--------------------------------------------------------------------
    // front stages and inverse path registers
    //--------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (en) begin
            mode_reg[0] <= rgbycc_pkg::mode_t'(s_mode);
            for (int j = 1; j < NST; j++) begin
                mode_reg[j] <= mode_reg[j-1];
            end

            // stage 0
            in_smp_reg[0] <= s_red_in;
            in_smp_reg[1] <= s_green_in;
            in_smp_reg[2] <= s_blue_in;
            in_y_reg      <= s_luma_in;
            in_pb_reg     <= s_blue_diff_in;
            in_pr_reg     <= s_red_diff_in;

            // stage 1
            fprod_reg <= fprod_next;
            iy_reg    <= rgbycc_pkg::FPROD_W'(rgbycc_pkg::INV_LUMA)
                       * rgbycc_pkg::FPROD_W'(in_y_reg);
            irv_reg   <= rgbycc_pkg::IPROD_W'($signed({1'b0, rgbycc_pkg::INV_RV}))
                       * rgbycc_pkg::IPROD_W'(in_pr_reg);
            igu_reg   <= rgbycc_pkg::IPROD_W'($signed({1'b0, rgbycc_pkg::INV_GU}))
                       * rgbycc_pkg::IPROD_W'(in_pb_reg);
            igv_reg   <= rgbycc_pkg::IPROD_W'($signed({1'b0, rgbycc_pkg::INV_GV}))
                       * rgbycc_pkg::IPROD_W'(in_pr_reg);
            ibu_reg   <= rgbycc_pkg::IPROD_W'($signed({1'b0, rgbycc_pkg::INV_BU}))
                       * rgbycc_pkg::IPROD_W'(in_pb_reg);

            for (int c = 0; c < 3; c++) begin
                // stage 2
                fsum_reg[c] <= fsum_next[c];
                isum_reg[c] <= isum_next[c];

                // stage 3
                fneg3_reg[c] <= fsum_reg[c] < 0;
                fabs_reg[c]  <= fabs_full[c][rgbycc_pkg::FABS_W-1:0];
                ipos_reg[c]  <= isum_reg[c] > 0;
                it_reg[c]    <= iw[c][41:18];

                // stage 4: magnitude * 8192 plus half the divisor
                fneg4_reg[c]  <= fneg3_reg[c];
                fnm_reg[c]    <= {1'b0, fabs_reg[c], {rgbycc_pkg::FRAC_SH{1'b0}}}
                               + NW'(dv_reg[DW-1:1]);
                izero4_reg[c] <= !ipos_reg[c];
                isat4_reg[c]  <= it_reg[c] >= rgbycc_pkg::T_SAT;
                it4_reg[c]    <= it_reg[c][21:0];
                itm_reg[c]    <= rgbycc_pkg::TM_W'(it_reg[c][21:0])
                               * rgbycc_pkg::TM_W'(rgbycc_pkg::RECIP);

                // stage 5
                izero5_reg[c] <= izero4_reg[c];
                isat5_reg[c]  <= isat4_reg[c];
                it5_reg[c]    <= it4_reg[c];
                iqe_reg[c]    <= itm_reg[c][rgbycc_pkg::TM_W-1:rgbycc_pkg::RECIP_SH];
                iprod_reg[c]  <= 23'(itm_reg[c][rgbycc_pkg::TM_W-1:rgbycc_pkg::RECIP_SH])
                               * 23'(rgbycc_pkg::DIV_K);

                // stage 6: estimate is low by at most one
                if (izero5_reg[c]) begin
                    rgb_reg[1][c] <= '0;
                end else if (isat5_reg[c]) begin
                    rgb_reg[1][c] <= 8'd255;
                end else begin
                    rgb_reg[1][c] <= iq[c][7:0];
                end
                for (int k = 2; k <= QW; k++) begin
                    rgb_reg[k][c] <= rgb_reg[k-1][c];
                end

                // divider stage 0: quotient too large for the bits kept
                rem_reg[0][c] <= fnm_reg[c];
                quo_reg[0][c] <= '0;
                neg_reg[0][c] <= fneg4_reg[c];
                ovf_reg[0][c] <= {1'b0, fnm_reg[c]} >= {dv_reg, {QW{1'b0}}};
            end
        end
    end

    //--------------------------------------------------------------------
    // restoring divider, one quotient bit per stage
    //--------------------------------------------------------------------
    for (genvar k = 1; k <= QW; k++) begin : g_div
        localparam int SH = QW - k;
        logic [NW:0] sub;
        logic        ge [3];

        assign sub = {{QW{1'b0}}, dv_reg} << SH;

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                ge[c] = {1'b0, rem_reg[k-1][c]} >= sub;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int c = 0; c < 3; c++) begin
                    rem_reg[k][c] <= ge[c] ? rem_reg[k-1][c] - sub[NW-1:0]
                                           : rem_reg[k-1][c];
                    quo_reg[k][c] <= quo_reg[k-1][c] | (QW'(ge[c]) << SH);
                    neg_reg[k][c] <= neg_reg[k-1][c];
                    ovf_reg[k][c] <= ovf_reg[k-1][c];
                end
            end
        end
    end

    //--------------------------------------------------------------------
    // saturation and result assembly
    //--------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            fq[c] = ovf_reg[QW][c] ? '1 : quo_reg[QW][c];
            if (c == 0) begin
                fmag[c] = (fq[c] > QW'(rgbycc_pkg::LUMA_MAX))
                        ? QW'(rgbycc_pkg::LUMA_MAX) : fq[c];
            end else begin
                fmag[c] = (fq[c] > QW'(rgbycc_pkg::CHROMA_MAX))
                        ? QW'(rgbycc_pkg::CHROMA_MAX) : fq[c];
            end
            // negative luma clamps to zero
            if (!neg_reg[QW][c]) begin
                fval[c] = fmag[c][15:0];
            end else if (c == 0) begin
                fval[c] = '0;
            end else begin
                fval[c] = -fmag[c][15:0];
            end
        end

        pd = '0;
        if (mode_reg[LAST] == rgbycc_pkg::MODE_INV) begin
            pd.red   = rgb_reg[QW][0];
            pd.green = rgb_reg[QW][1];
            pd.blue  = rgb_reg[QW][2];
        end else begin
            pd.luma      = fval[0];
            pd.blue_diff = $signed(fval[1]);
            pd.red_diff  = $signed(fval[2]);
        end
    end

    //--------------------------------------------------------------------
    // output register with skid stage
    //--------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_vld_reg) begin
                m_valid_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                m_valid_reg <= vld_reg[LAST];
            end
        end else if (vld_reg[LAST] && en) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            out_reg <= skid_vld_reg ? skid_reg : pd;
        end else if (vld_reg[LAST] && en) begin
            skid_reg <= pd;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_luma_out      = out_reg.luma;
    assign m_blue_diff_out = out_reg.blue_diff;
    assign m_red_diff_out  = out_reg.red_diff;
    assign m_red_out       = out_reg.red;
    assign m_green_out     = out_reg.green;
    assign m_blue_out      = out_reg.blue;

    //--------------------------------------------------------------------
    // assertions
    //--------------------------------------------------------------------
    // a full skid stage always sits behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_valid_reg)
        else $error("skid stage full while output register empty");

    // a frozen pipeline keeps its last item
    a_last_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && vld_reg[LAST]) |=> vld_reg[LAST])
        else $error("item lost from last stage during stall");

    // only one direction's fields carry data
    a_one_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_luma_out == 16'd0 && m_blue_diff_out == 16'sd0
                          && m_red_diff_out == 16'sd0)
                      || (m_red_out == 8'd0 && m_green_out == 8'd0
                          && m_blue_out == 8'd0)))
        else $error("forward and inverse fields both nonzero");

    // luma saturates at one
    a_luma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_luma_out <= rgbycc_pkg::LUMA_MAX))
        else $error("luma above saturation limit");

endmodule

>>> tb/tb.sv
// tb: self-checking bench for rgb_ypbpr_color_convert, one pixel in and one result out
// drives the pixel and result channels with random pacing, and writes the denominator between phases
// depends on rgbycc_pkg and the converter rtl

typedef struct packed {
    rgbycc_pkg::mode_t  mode;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [15:0]        luma;
    logic signed [15:0] blue_diff;
    logic signed [15:0] red_diff;
} pixel_t;

class ycc_scoreboard;
    rgbycc_pkg::result_t expected_pixels[$];
    logic [15:0]         denominator;
    int unsigned         errors;
    int unsigned         results_seen;

    function new();
        denominator  = 16'd255;
        errors       = 0;
        results_seen = 0;
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction

    function longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // num * 2^15 / den, rounded half away from zero
    function longint q15_round(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned quo;
        mag = (num < 0) ? -num : num;
        quo = (mag * 64'd32768 + den / 64'd2) / den;
        return (num < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    // 255 * num / (2^15 * 10^6), truncated toward zero, then clamped
    function logic [7:0] to_channel(longint num);
        longint v;
        v = (64'sd255 * num) / 64'sd32768000000;
        return 8'(clip(v, 0, 255));
    endfunction

    function rgbycc_pkg::result_t convert_pixel(pixel_t px);
        rgbycc_pkg::result_t res;
        longint              r, g, b, yv, pb, pr;
        longint unsigned     den;
        res = '0;
        if (px.mode == rgbycc_pkg::MODE_FWD) begin
            r   = longint'(px.red);
            g   = longint'(px.green);
            b   = longint'(px.blue);
            den = (denominator == 16'd0) ? 64'd1 : 64'(denominator);
            den = den * 64'd1000000;
            yv  = clip(q15_round(299000 * r + 587000 * g + 114000 * b, den), 0, 32768);
            pb  = clip(q15_round(-168736 * r - 331264 * g + 500000 * b, den), -16384, 16384);
            pr  = clip(q15_round(500000 * r - 418688 * g - 81312 * b, den), -16384, 16384);
            res.luma      = yv[15:0];
            res.blue_diff = pb[15:0];
            res.red_diff  = pr[15:0];
        end else begin
            yv = longint'(px.luma) * 1000000;
            pb = longint'($signed(px.blue_diff));
            pr = longint'($signed(px.red_diff));
            res.red   = to_channel(yv + 1402000 * pr);
            res.green = to_channel(yv - 344136 * pb - 714136 * pr);
            res.blue  = to_channel(yv + 1772000 * pb);
        end
        return res;
    endfunction

    function void note_input(pixel_t px);
        expected_pixels.push_back(convert_pixel(px));
    endfunction

    task report(string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(rgbycc_pkg::result_t got);
        rgbycc_pkg::result_t want;
        results_seen++;
        if (expected_pixels.size() == 0) begin
            report("result with no pixel outstanding");
            return;
        end
        want = expected_pixels.pop_front();
        compare_field("luma", got.luma, want.luma);
        compare_field("pb", got.blue_diff, want.blue_diff);
        compare_field("pr", got.red_diff, want.red_diff);
        compare_field("red", got.red, want.red);
        compare_field("green", got.green, want.green);
        compare_field("blue", got.blue, want.blue);
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned DRAIN_CYCLES   = 30;
    localparam int unsigned PHASE_ITEMS    = 313;
    localparam int unsigned LONG_HOLD      = 300;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_data  = 16'd0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    pixel_t             tx_pixel  = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [15:0]        m_luma_out;
    logic signed [15:0] m_blue_diff_out;
    logic signed [15:0] m_red_diff_out;
    logic [7:0]         m_red_out;
    logic [7:0]         m_green_out;
    logic [7:0]         m_blue_out;

    ycc_scoreboard sb;
    bit            tx_idle_on    = 1'b1;
    bit            rx_idle_on    = 1'b1;
    int unsigned   rx_hold_cycles = 0;
    int unsigned   cycle_count   = 0;

    rgb_ypbpr_color_convert i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (tx_pixel.mode),
        .s_red_in        (tx_pixel.red),
        .s_green_in      (tx_pixel.green),
        .s_blue_in       (tx_pixel.blue),
        .s_luma_in       (tx_pixel.luma),
        .s_blue_diff_in  (tx_pixel.blue_diff),
        .s_red_diff_in   (tx_pixel.red_diff),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_luma_out      (m_luma_out),
        .m_blue_diff_out (m_blue_diff_out),
        .m_red_diff_out  (m_red_diff_out),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // every transfer is seen here, on the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.denominator = cfg_data;
            if (s_valid && s_ready)
                sb.note_input(tx_pixel);
            if (m_valid && m_ready)
                sb.check_result('{m_luma_out, m_blue_diff_out, m_red_diff_out,
                                  m_red_out, m_green_out, m_blue_out});
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int unsigned stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (rx_hold_cycles != 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = rx_idle_on ? $urandom_range(0, 8) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    function automatic logic [15:0] pick_one(logic [15:0] a, logic [15:0] b,
                                             logic [15:0] c, logic [15:0] d);
        case ($urandom_range(0, 3))
            0:       return a;
            1:       return b;
            2:       return c;
            default: return d;
        endcase
    endfunction

    function automatic pixel_t fwd_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        pixel_t px;
        px.mode      = rgbycc_pkg::MODE_FWD;
        px.red       = r;
        px.green     = g;
        px.blue      = b;
        px.luma      = 16'($urandom);
        px.blue_diff = 16'($urandom);
        px.red_diff  = 16'($urandom);
        return px;
    endfunction

    function automatic pixel_t inv_pixel(logic [15:0] y, logic signed [15:0] pb,
                                         logic signed [15:0] pr);
        pixel_t px;
        px.mode      = rgbycc_pkg::MODE_INV;
        px.red       = 16'($urandom);
        px.green     = 16'($urandom);
        px.blue      = 16'($urandom);
        px.luma      = y;
        px.blue_diff = pb;
        px.red_diff  = pr;
        return px;
    endfunction

    // mostly in-range pixels, some at the extremes, some raw noise
    function automatic pixel_t random_pixel(logic [15:0] den);
        pixel_t      px;
        int unsigned top;
        int unsigned kind;
        top  = (den == 16'd0) ? 1 : den;
        kind = $urandom_range(0, 9);
        px   = fwd_pixel(16'($urandom), 16'($urandom), 16'($urandom));
        if ($urandom_range(0, 1) == 1)
            px.mode = rgbycc_pkg::MODE_INV;
        if (px.mode == rgbycc_pkg::MODE_FWD) begin
            if (kind <= 6) begin
                px.red   = 16'($urandom_range(0, top));
                px.green = 16'($urandom_range(0, top));
                px.blue  = 16'($urandom_range(0, top));
            end else if (kind <= 8) begin
                px.red   = pick_one(16'd0, 16'(top), 16'hFFFF, 16'd0);
                px.green = pick_one(16'd0, 16'(top), 16'hFFFF, 16'(top));
                px.blue  = pick_one(16'd0, 16'(top), 16'hFFFF, 16'd0);
            end
        end else begin
            if (kind <= 6) begin
                px.luma      = 16'($urandom_range(0, 32768));
                px.blue_diff = 16'(int'($urandom_range(0, 32768)) - 16384);
                px.red_diff  = 16'(int'($urandom_range(0, 32768)) - 16384);
            end else if (kind <= 8) begin
                px.luma      = pick_one(16'd0, 16'd32768, 16'hFFFF, 16'd32768);
                px.blue_diff = pick_one(16'hC000, 16'h4000, 16'h8000, 16'h7FFF);
                px.red_diff  = pick_one(16'hC000, 16'h4000, 16'h8000, 16'h7FFF);
            end
        end
        return px;
    endfunction

    // entered and left on a falling edge; valid stays up between back-to-back pixels
    task automatic send_pixel(pixel_t px);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        tx_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_denominator(logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] phase_den [6];
        sb = new();
        phase_den    = '{16'd1, 16'd65535, 16'd0, 16'd0, 16'd4095, 16'd255};
        phase_den[3] = 16'($urandom_range(2, 65534));
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed pixels at the reset denominator
        send_pixel(fwd_pixel(16'd0, 16'd0, 16'd0));
        send_pixel(fwd_pixel(16'd255, 16'd255, 16'd255));
        send_pixel(fwd_pixel(16'd255, 16'd0, 16'd0));
        send_pixel(fwd_pixel(16'd0, 16'd255, 16'd0));
        send_pixel(fwd_pixel(16'd0, 16'd0, 16'd255));
        send_pixel(fwd_pixel(16'd1, 16'd2, 16'd3));
        send_pixel(fwd_pixel(16'd128, 16'd64, 16'd200));
        // samples above the denominator saturate
        send_pixel(fwd_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(fwd_pixel(16'hFFFF, 16'd0, 16'd0));
        send_pixel(fwd_pixel(16'd0, 16'hFFFF, 16'd0));
        send_pixel(fwd_pixel(16'd0, 16'd0, 16'hFFFF));
        send_pixel(inv_pixel(16'd0, 16'sd0, 16'sd0));
        send_pixel(inv_pixel(16'd32768, 16'sd0, 16'sd0));
        send_pixel(inv_pixel(16'd32768, 16'sd16384, 16'sd16384));
        send_pixel(inv_pixel(16'd0, -16'sd16384, -16'sd16384));
        send_pixel(inv_pixel(16'd16384, -16'sd16384, 16'sd16384));
        send_pixel(inv_pixel(16'd16384, 16'sd16384, -16'sd16384));
        send_pixel(inv_pixel(16'd0, 16'sd16384, 16'sd0));
        send_pixel(inv_pixel(16'd32768, -16'sd16384, 16'sd0));
        send_pixel(inv_pixel(16'd1, -16'sd1, 16'sd1));
        // inverse fields beyond their nominal ranges
        send_pixel(inv_pixel(16'hFFFF, 16'sh7FFF, 16'sh8000));
        send_pixel(inv_pixel(16'd0, 16'sh8000, 16'sh7FFF));

        foreach (phase_den[p]) begin
            drain_results();
            write_denominator(phase_den[p]);
            for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 50 == 0) begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    rx_idle_on = ($urandom_range(0, 3) != 0);
                end
                // hold the result side off while pixels keep coming, to back up the pipe
                if (p == 1 && i == 100) begin
                    rx_hold_cycles = LONG_HOLD;
                    tx_idle_on     = 1'b0;
                end
                if (p == 4 && i == 150)
                    drain_results();
                send_pixel(random_pixel(phase_den[p]));
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
